/* sv/b64e_pkg.sv */
// Package: shared item types, job type and the base64 character lookup.
package b64e_pkg;

   localparam logic [6:0] PAD_CHAR  = 7'h3d;
   localparam int         JOB_SLOTS = 4;
   localparam int         Q_DEPTH   = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [6:0] code_char;
      logic       last_out;
   } rsp_type;

   typedef struct packed {
      logic [JOB_SLOTS-1:0][6:0] chars;
      logic [1:0]                final_idx;
      logic                      last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [6:0] b64_char(input logic [5:0] v);
      logic [6:0] r;
      if (v < 6'd26) begin
         r = 7'(v) + 7'd65;
      end else if (v < 6'd52) begin
         r = 7'(v) + 7'd71;
      end else if (v < 6'd62) begin
         r = 7'(v) - 7'd4;
      end else if (v == 6'd62) begin
         r = 7'h2b;
      end else begin
         r = 7'h2f;
      end
      return r;
   endfunction

endpackage

/* sv/b64e_front.sv */
// Front end: takes bytes, tracks group phase and carry, builds one job per byte.
module b64e_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  b64e_pkg::req_type req_data,
   input  logic             q_full,
   output logic             push,
   output b64e_pkg::job_type job
);
   import b64e_pkg::*;

   localparam logic [1:0] PH_ZERO = 2'd0;
   localparam logic [1:0] PH_ONE  = 2'd1;
   localparam logic [1:0] PH_TWO  = 2'd2;

   logic [3:0] carry_ff, carry_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] b;
   logic       fin;

   assign push = req_valid && !q_full;
   assign b    = req_data.data_byte;
   assign fin  = req_data.last_in;

   always_comb begin
      job       = '0;
      job.last  = fin;
      carry_in  = carry_ff;
      phase_in  = phase_ff;
      case (phase_ff)
         PH_ONE: begin
            job.chars[0] = b64_char({carry_ff[1:0], b[7:4]});
            if (fin) begin
               job.chars[1]  = b64_char({b[3:0], 2'b00});
               job.chars[2]  = PAD_CHAR;
               job.final_idx = 2'd2;
            end else begin
               job.final_idx = 2'd0;
               carry_in      = b[3:0];
               phase_in      = PH_TWO;
            end
         end
         PH_TWO: begin
            job.chars[0]  = b64_char({carry_ff, b[7:6]});
            job.chars[1]  = b64_char(b[5:0]);
            job.final_idx = 2'd1;
            carry_in      = '0;
            phase_in      = PH_ZERO;
         end
         default: begin
            job.chars[0] = b64_char(b[7:2]);
            if (fin) begin
               job.chars[1]  = b64_char({b[1:0], 4'b0000});
               job.chars[2]  = PAD_CHAR;
               job.chars[3]  = PAD_CHAR;
               job.final_idx = 2'd3;
            end else begin
               job.final_idx = 2'd0;
               carry_in      = {2'b00, b[1:0]};
               phase_in      = PH_ONE;
            end
         end
      endcase
      if (fin) begin
         carry_in = '0;
         phase_in = PH_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
         phase_ff <= PH_ZERO;
      end else if (push) begin
         carry_ff <= carry_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* sv/b64e_queue.sv */
// Two-entry job queue between front and back.
module b64e_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64e_pkg::job_type     push_job,
   input  logic                  pop,
   output b64e_pkg::job_type     head_job,
   output b64e_pkg::q_status_type status
);
   import b64e_pkg::*;

   localparam int PW = $clog2(Q_DEPTH);
   localparam int CW = $clog2(Q_DEPTH + 1);

   job_type        slot_ff [Q_DEPTH];
   logic [PW-1:0]  wr_ff, rd_ff;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_pop;

   assign status.full  = (count_ff == CW'(Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = slot_ff[rd_ff];
   assign do_pop       = pop && !status.empty;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

/* sv/b64e_back.sv */
// Back end: head job chars go to the output register, one per unstalled cycle.
module b64e_back (
   input  logic                   clock,
   input  logic                   reset,
   input  b64e_pkg::job_type      head_job,
   input  b64e_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   output b64e_pkg::rsp_type      rsp_data,
   input  logic                   rsp_stall
);
   import b64e_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       load, at_end;

   assign load   = (!rsp_valid_ff || !rsp_stall) && !q_status.empty;
   assign at_end = (idx_ff == head_job.final_idx);
   assign pop    = load && at_end;

   always_comb begin
      rsp_valid_in          = rsp_valid_ff;
      rsp_data_in           = rsp_data_ff;
      idx_in                = idx_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.code_char = head_job.chars[idx_ff];
         rsp_data_in.last_out  = head_job.last && at_end;
         idx_in                = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* sv/base64_stream_encoder.sv */
// Top level: streaming base64 encoder, front end, job queue and back end.
//
//   channel  direction  handshake              item
//   req      in         req_valid / req_stall  req_type: data_byte, last_in
//   rsp      out        rsp_valid / rsp_stall  rsp_type: code_char, last_out
//
// One character leaves per cycle from the back end's output register while rsp_stall
// is low; a byte gives one or two characters, a final byte two to four, so bytes flow
// at up to one a cycle and settle at four characters per three bytes.
// Reset clears phase, carry, queue pointers and output valid.
// req_stall is high while the two-entry job queue is full.
module base64_stream_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64e_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64e_pkg::rsp_type rsp_data
);
   import b64e_pkg::*;

   logic         push, pop;
   job_type      push_job, head_job;
   q_status_type q_status;

   assign req_stall = q_status.full;

   b64e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_status.full),
      .push      (push),
      .job       (push_job)
   );

   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_idle_stays: assert property (@(posedge clock) disable iff (reset)
      (q_status.empty && !rsp_valid && !push) |=> !rsp_valid)
      else $error("character produced without a job");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_status.empty)
      else $error("accepted item lost from queue");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

/* tb/sv/b64_stream_checker.sv */
// Checker: watches both channels, predicts the base64 characters and compares them.
module b64_stream_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  b64e_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  b64e_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import b64e_pkg::*;

   typedef enum logic [1:0] {
      GRP_FIRST  = 2'd0,
      GRP_SECOND = 2'd1,
      GRP_THIRD  = 2'd2
   } grp_pos_type;

   localparam logic [511:0] SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam logic [6:0] PAD_SYM = 7'h3d;

   rsp_type     chars_due[$];
   logic [3:0]  leftover;
   grp_pos_type grp_pos;

   initial begin
      fail_count = 0;
      pending    = 0;
      leftover   = '0;
      grp_pos    = GRP_FIRST;
   end

   function automatic logic [6:0] symbol_of(input logic [5:0] v);
      logic [7:0] ch;
      ch = SYMBOLS[8*(63-v) +: 8];
      return ch[6:0];
   endfunction

   task automatic queue_char(input logic [6:0] ch, input logic fin);
      rsp_type r;
      r.code_char = ch;
      r.last_out  = fin;
      chars_due.push_back(r);
   endtask

   task automatic encode_byte(input req_type item);
      logic [7:0] b;
      logic       fin;
      b   = item.data_byte;
      fin = item.last_in;
      case (grp_pos)
         GRP_SECOND: begin
            queue_char(symbol_of({leftover[1:0], b[7:4]}), 1'b0);
            if (fin) begin
               queue_char(symbol_of({b[3:0], 2'b00}), 1'b0);
               queue_char(PAD_SYM, 1'b1);
            end else begin
               leftover = b[3:0];
               grp_pos  = GRP_THIRD;
            end
         end
         GRP_THIRD: begin
            queue_char(symbol_of({leftover, b[7:6]}), 1'b0);
            queue_char(symbol_of(b[5:0]), fin);
            leftover = '0;
            grp_pos  = GRP_FIRST;
         end
         default: begin
            queue_char(symbol_of(b[7:2]), 1'b0);
            if (fin) begin
               queue_char(symbol_of({b[1:0], 4'b0000}), 1'b0);
               queue_char(PAD_SYM, 1'b0);
               queue_char(PAD_SYM, 1'b1);
            end else begin
               leftover = {2'b00, b[1:0]};
               grp_pos  = GRP_SECOND;
            end
         end
      endcase
      if (fin) begin
         leftover = '0;
         grp_pos  = GRP_FIRST;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            encode_byte(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (chars_due.size() == 0) begin
               $error("unexpected item: code_char %h last_out %b",
                      rsp_data.code_char, rsp_data.last_out);
               fail_count++;
            end else begin
               want = chars_due.pop_front();
               if (rsp_data.code_char !== want.code_char) begin
                  $error("code_char: expected %h, actual %h",
                         want.code_char, rsp_data.code_char);
                  fail_count++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $error("last_out: expected %b, actual %b",
                         want.last_out, rsp_data.last_out);
                  fail_count++;
               end
            end
         end
         pending = chars_due.size();
      end
   end

endmodule

/* tb/sv/tb.sv */
// Testbench top: clock, reset, byte stimulus, output stall and the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b64e_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int send_idle_pct  = 15;
   int recv_stall_pct = 74;
   int quiet_cycles   = 0;

   base64_stream_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   b64_stream_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // entered and left at a falling edge; valid stays high after acceptance
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data.data_byte <= b;
      req_data.last_in   <= fin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic random_messages(input int count);
      int left;
      int len;
      left = count;
      while (left > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom), i == len - 1);
         end
         left -= len;
      end
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // final byte at each group position, extreme values
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      // "++++", "////", then a lone byte
      send_byte(8'hfb, 1'b0);
      send_byte(8'hef, 1'b0);
      send_byte(8'hbe, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h4d, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6e, 1'b0);
      send_byte(8'h4d, 1'b0);
      send_byte(8'h61, 1'b1);
      drain();

      random_messages(150);
      drain();
      send_idle_pct  = 74;
      recv_stall_pct = 15;
      random_messages(155);
      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_messages(155);
      drain();

      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
